>>> sv/ffga_pkg.sv
// Shared constants, types and codes for the first-fit gap allocator.
// No dependencies; every other file refers to it by scoped names.
package ffga_pkg;

    localparam int GAP_SLOTS     = 128;
    localparam int SLOT_BITS     = $clog2(GAP_SLOTS);
    localparam int ADDR_BITS     = 48;
    localparam int MIN_BITS      = 32;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [MIN_BITS-1:0] MIN_GAP_RESET = 32'd4096;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [SLOT_BITS-1:0] t_slot;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_FROM_GAP      = 3'd0,
        ST_FROM_FRONTIER = 3'd1,
        ST_RECORDED      = 3'd2,
        ST_TOO_SMALL     = 3'd3,
        ST_TABLE_FULL    = 3'd4,
        ST_OVERFLOW      = 3'd5
    } t_status;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_GAP  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRONTIER = 4'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_FRONT,
        S_DONE
    } t_state;

endpackage

>>> sv/ffga_if.sv
// Handshake channels of the first-fit gap allocator: request, response, configuration.
// Depends on ffga_pkg for field widths.
interface ffga_req_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [ffga_pkg::ADDR_BITS-1:0]  chunk_start;
    logic [ffga_pkg::ADDR_BITS-1:0]  chunk_size;

    modport source (output valid, operation, chunk_start, chunk_size, input ready);
    modport sink   (input valid, operation, chunk_start, chunk_size, output ready);
endinterface

interface ffga_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ffga_pkg::ADDR_BITS-1:0]  block_address;
    logic [2:0]                      status;

    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

interface ffga_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ffga_pkg::CFG_IDX_BITS-1:0]   index;
    logic [ffga_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/first_fit_gap_allocator.sv
// First-fit gap allocator: gap table memory, slot scan sequencer, frontier pointer.
// Depends on ffga_pkg and the channel interfaces in ffga_if.sv.
//
// The block takes one request at a time. It walks the gap table one slot per cycle
// through the table memory's single read port; a release smaller than the minimum skips
// the walk, an allocate that misses every gap falls through to the frontier, a release
// stops at the first empty slot and an allocate that hits stops at the hit slot.
// A finished result waits in an output register while the next request is taken.
// Slot occupancy lives in flip-flops cleared by reset, so no clearing pass is needed.
// Configuration writes are accepted every cycle and belong to idle periods.
module first_fit_gap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffga_req_if.sink    i_req,
    ffga_rsp_if.source  o_rsp,
    ffga_cfg_if.sink    i_cfg
);

    localparam int AB = ffga_pkg::ADDR_BITS;
    localparam int NS = ffga_pkg::GAP_SLOTS;

    ffga_pkg::t_state  r_state, n_state;
    logic              r_op, n_op;
    ffga_pkg::t_addr   r_cstart, n_cstart;
    ffga_pkg::t_addr   r_csize, n_csize;
    ffga_pkg::t_addr   r_addr, n_addr;
    ffga_pkg::t_status r_status, n_status;
    ffga_pkg::t_slot   r_idx, n_idx;
    logic              r_issue_done, n_issue_done;
    logic              r_q_vld, n_q_vld;
    ffga_pkg::t_slot   r_q_idx, n_q_idx;
    ffga_pkg::t_addr   r_rd_start, r_rd_size;
    logic              r_fe_vld, n_fe_vld;
    ffga_pkg::t_slot   r_fe_idx, n_fe_idx;
    ffga_pkg::t_slot   r_hit_idx, n_hit_idx;
    ffga_pkg::t_addr   r_left, n_left;
    logic [NS-1:0]     r_occ, n_occ;
    ffga_pkg::t_addr   r_fp, n_fp;
    logic [ffga_pkg::MIN_BITS-1:0] r_min, n_min;
    logic              r_out_vld, n_out_vld;
    ffga_pkg::t_addr   r_out_addr, n_out_addr;
    ffga_pkg::t_status r_out_status, n_out_status;

    ffga_pkg::t_addr   r_mem_start [NS];
    ffga_pkg::t_addr   r_mem_size  [NS];

    logic              mem_we;
    ffga_pkg::t_slot   mem_waddr;
    ffga_pkg::t_addr   mem_wstart;
    ffga_pkg::t_addr   mem_wsize;

    ffga_pkg::t_addr   min_ext;
    logic [AB:0]       front_sum;
    ffga_pkg::t_addr   left_start;
    logic              q_occ;
    logic              q_last;
    logic              req_acc;
    ffga_pkg::t_slot   left_slot;

    assign min_ext    = {{(AB - ffga_pkg::MIN_BITS){1'b0}}, r_min};
    assign front_sum  = {1'b0, r_fp} + {1'b0, r_csize};
    assign left_start = r_addr + r_csize;
    assign q_occ      = r_occ[r_q_idx];
    assign q_last     = (r_q_idx == {ffga_pkg::SLOT_BITS{1'b1}});
    assign left_slot  = r_fe_vld ? r_fe_idx : r_hit_idx;

    assign i_req.ready         = (r_state == ffga_pkg::S_IDLE);
    assign req_acc             = i_req.valid && i_req.ready;
    assign i_cfg.ready         = 1'b1;
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.status        = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_cstart     = r_cstart;
        n_csize      = r_csize;
        n_addr       = r_addr;
        n_status     = r_status;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_q_vld      = 1'b0;
        n_q_idx      = r_idx;
        n_fe_vld     = r_fe_vld;
        n_fe_idx     = r_fe_idx;
        n_hit_idx    = r_hit_idx;
        n_left       = r_left;
        n_occ        = r_occ;
        n_fp         = r_fp;
        n_min        = r_min;
        n_out_vld    = r_out_vld;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_q_idx;
        mem_wstart   = r_cstart;
        mem_wsize    = r_csize;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ffga_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_op         = i_req.operation;
                    n_cstart     = i_req.chunk_start;
                    n_csize      = i_req.chunk_size;
                    n_addr       = '0;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    n_fe_vld     = 1'b0;
                    if ((i_req.operation == ffga_pkg::OP_RELEASE) &&
                        ((i_req.chunk_size == '0) || (i_req.chunk_size < min_ext))) begin
                        n_status = ffga_pkg::ST_TOO_SMALL;
                        n_state  = ffga_pkg::S_DONE;
                    end else begin
                        n_state = ffga_pkg::S_SCAN;
                    end
                end
            end
            ffga_pkg::S_SCAN: begin
                n_q_vld = !r_issue_done;
                if (!r_issue_done) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == {ffga_pkg::SLOT_BITS{1'b1}}) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_q_vld) begin
                    if (r_op == ffga_pkg::OP_RELEASE) begin
                        if (!q_occ) begin
                            mem_we         = 1'b1;
                            n_occ[r_q_idx] = 1'b1;
                            n_status       = ffga_pkg::ST_RECORDED;
                            n_state        = ffga_pkg::S_DONE;
                        end else if (q_last) begin
                            n_status = ffga_pkg::ST_TABLE_FULL;
                            n_state  = ffga_pkg::S_DONE;
                        end
                    end else begin
                        if (q_occ && (r_rd_size >= r_csize)) begin
                            n_hit_idx = r_q_idx;
                            n_addr    = r_rd_start;
                            n_left    = r_rd_size - r_csize;
                            n_state   = ffga_pkg::S_SPLIT;
                        end else begin
                            if (!q_occ && !r_fe_vld) begin
                                n_fe_vld = 1'b1;
                                n_fe_idx = r_q_idx;
                            end
                            if (q_last) begin
                                n_state = ffga_pkg::S_FRONT;
                            end
                        end
                    end
                end
            end
            ffga_pkg::S_SPLIT: begin
                n_occ[r_hit_idx] = 1'b0;
                if ((r_left != '0) && (r_left >= min_ext)) begin
                    mem_we           = 1'b1;
                    mem_waddr        = left_slot;
                    mem_wstart       = left_start;
                    mem_wsize        = r_left;
                    n_occ[left_slot] = 1'b1;
                end
                n_status = ffga_pkg::ST_FROM_GAP;
                n_state  = ffga_pkg::S_DONE;
            end
            ffga_pkg::S_FRONT: begin
                if (front_sum[AB]) begin
                    n_status = ffga_pkg::ST_OVERFLOW;
                end else begin
                    n_addr   = r_fp;
                    n_fp     = front_sum[AB-1:0];
                    n_status = ffga_pkg::ST_FROM_FRONTIER;
                end
                n_state = ffga_pkg::S_DONE;
            end
            ffga_pkg::S_DONE: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_addr   = r_addr;
                    n_out_status = r_status;
                    n_state      = ffga_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffga_pkg::S_IDLE;
            end
        endcase

        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                ffga_pkg::CFG_MIN_GAP:  n_min = i_cfg.data[ffga_pkg::MIN_BITS-1:0];
                ffga_pkg::CFG_FRONTIER: n_fp  = i_cfg.data[AB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffga_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_done <= 1'b0;
            r_q_vld      <= 1'b0;
            r_fe_vld     <= 1'b0;
            r_occ        <= '0;
            r_fp         <= '0;
            r_min        <= ffga_pkg::MIN_GAP_RESET;
            r_out_vld    <= 1'b0;
        end else begin
            r_issue_done <= n_issue_done;
            r_q_vld      <= n_q_vld;
            r_fe_vld     <= n_fe_vld;
            r_occ        <= n_occ;
            r_fp         <= n_fp;
            r_min        <= n_min;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_cstart     <= n_cstart;
        r_csize      <= n_csize;
        r_addr       <= n_addr;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_q_idx      <= n_q_idx;
        r_fe_idx     <= n_fe_idx;
        r_hit_idx    <= n_hit_idx;
        r_left       <= n_left;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_start[mem_waddr] <= mem_wstart;
            r_mem_size[mem_waddr]  <= mem_wsize;
        end
        r_rd_start <= r_mem_start[r_idx];
        r_rd_size  <= r_mem_size[r_idx];
    end

    a_left_before_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffga_pkg::S_SPLIT && r_fe_vld) |-> (r_fe_idx < r_hit_idx))
        else $error("leftover slot not ahead of hit slot");

    a_fp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ffga_pkg::S_FRONT && !i_cfg.valid) |=> $stable(r_fp))
        else $error("frontier moved outside frontier step");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ffga_pkg::ST_RECORDED ||
                         o_rsp.status == ffga_pkg::ST_TOO_SMALL ||
                         o_rsp.status == ffga_pkg::ST_TABLE_FULL ||
                         o_rsp.status == ffga_pkg::ST_OVERFLOW))
        |-> (o_rsp.block_address == '0))
        else $error("nonzero address on non-allocating result");

endmodule

>>> verif/first_fit_gap_allocator_tb.sv
// Self-checking testbench for first_fit_gap_allocator: directed and random release/allocate
// traffic, with a model of the gap table and frontier predicting every response.
// Depends on ffga_pkg, the channel interfaces in ffga_if.sv and the allocator RTL.
module first_fit_gap_allocator_tb;

    localparam int              CYCLE_LIMIT   = 2_000_000;
    localparam int              SETTLE_CYCLES = ffga_pkg::GAP_SLOTS + 8;
    localparam ffga_pkg::t_addr ADDR_MAX      = '1;

    localparam logic [ffga_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = ffga_pkg::CFG_FRONTIER + 1'b1;
    localparam logic [ffga_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = '1;

    typedef struct packed {
        ffga_pkg::t_addr   block_address;
        ffga_pkg::t_status status;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffga_req_if req_ch ();
    ffga_rsp_if rsp_ch ();
    ffga_cfg_if cfg_ch ();

    first_fit_gap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    ffga_pkg::t_addr                gap_base [ffga_pkg::GAP_SLOTS];
    ffga_pkg::t_addr                gap_len  [ffga_pkg::GAP_SLOTS];
    ffga_pkg::t_addr                frontier_ptr;
    logic [ffga_pkg::MIN_BITS-1:0]  min_gap;
    t_grant                         grant_queue [$];
    int                             error_count = 0;
    int                             cycle_count = 0;
    bit                             steady = 1'b0;

    function automatic void clear_model();
        for (int i = 0; i < ffga_pkg::GAP_SLOTS; i++) begin
            gap_base[i] = '0;
            gap_len[i]  = '0;
        end
        frontier_ptr = '0;
        min_gap      = ffga_pkg::MIN_GAP_RESET;
    endfunction

    function automatic ffga_pkg::t_status store_gap(ffga_pkg::t_addr base,
                                                    ffga_pkg::t_addr len);
        if (len == 0 || len < ffga_pkg::t_addr'(min_gap)) begin
            return ffga_pkg::ST_TOO_SMALL;
        end
        for (int i = 0; i < ffga_pkg::GAP_SLOTS; i++) begin
            if (gap_len[i] == 0) begin
                gap_base[i] = base;
                gap_len[i]  = len;
                return ffga_pkg::ST_RECORDED;
            end
        end
        return ffga_pkg::ST_TABLE_FULL;
    endfunction

    function automatic t_grant predict_grant(ffga_pkg::t_op op, ffga_pkg::t_addr base,
                                             ffga_pkg::t_addr len);
        int              hit;
        ffga_pkg::t_addr spare;
        t_grant          g;
        g.block_address = '0;
        if (op == ffga_pkg::OP_RELEASE) begin
            g.status = store_gap(base, len);
        end else begin
            hit = -1;
            for (int i = 0; i < ffga_pkg::GAP_SLOTS && hit < 0; i++) begin
                if (gap_len[i] != 0 && gap_len[i] >= len) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                spare           = gap_len[hit] - len;
                g.block_address = gap_base[hit];
                gap_base[hit]   = '0;
                gap_len[hit]    = '0;
                void'(store_gap(g.block_address + len, spare));
                g.status        = ffga_pkg::ST_FROM_GAP;
            end else if (len > ADDR_MAX - frontier_ptr) begin
                g.status = ffga_pkg::ST_OVERFLOW;
            end else begin
                g.block_address = frontier_ptr;
                frontier_ptr    = frontier_ptr + len;
                g.status        = ffga_pkg::ST_FROM_FRONTIER;
            end
        end
        return g;
    endfunction

    function automatic int occupied_slots();
        int n = 0;
        for (int i = 0; i < ffga_pkg::GAP_SLOTS; i++) begin
            if (gap_len[i] != 0) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic ffga_pkg::t_addr rand_addr();
        return ffga_pkg::t_addr'({$urandom, $urandom});
    endfunction

    function automatic ffga_pkg::t_addr pick_size();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return ffga_pkg::t_addr'($urandom_range(8192, 1));
            4, 5:       return ffga_pkg::t_addr'($urandom);
            6, 7:       return rand_addr();
            8:          return ffga_pkg::t_addr'(min_gap)
                               + ffga_pkg::t_addr'($urandom_range(2, 0)) - 1'b1;
            default:    return rand_addr() >> $urandom_range(47, 0);
        endcase
    endfunction

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(12, 0);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(ffga_pkg::t_op op, ffga_pkg::t_addr base,
                                ffga_pkg::t_addr len);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.chunk_start <= base;
        req_ch.chunk_size  <= len;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        grant_queue.push_back(predict_grant(op, base, len));
    endtask

    task automatic settle();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (grant_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [ffga_pkg::CFG_IDX_BITS-1:0] idx,
                                  logic [ffga_pkg::CFG_DATA_BITS-1:0] data);
        settle();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        if (idx == ffga_pkg::CFG_MIN_GAP) begin
            min_gap = data[ffga_pkg::MIN_BITS-1:0];
        end else if (idx == ffga_pkg::CFG_FRONTIER) begin
            frontier_ptr = data[ffga_pkg::ADDR_BITS-1:0];
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_min_gap(logic [ffga_pkg::MIN_BITS-1:0] value);
        logic [ffga_pkg::CFG_DATA_BITS-1:0] word;
        word                          = rand_addr();
        word[ffga_pkg::MIN_BITS-1:0]  = value;
        write_register(ffga_pkg::CFG_MIN_GAP, word);
    endtask

    // allocate each tracked gap by its exact size so no leftover is kept
    task automatic empty_gap_table();
        for (int i = 0; i < ffga_pkg::GAP_SLOTS; i++) begin
            if (gap_len[i] != 0) begin
                send_request(ffga_pkg::OP_ALLOC, rand_addr(), gap_len[i]);
            end
        end
    endtask

    initial begin
        t_grant want;
        int     stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait();
            @(negedge i_clk);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
            if (grant_queue.size() == 0) begin
                error_count++;
                $display("%0t: unexpected item, expected none, got addr %h status %0d",
                         $time, rsp_ch.block_address, rsp_ch.status);
            end else begin
                want = grant_queue.pop_front();
                if (rsp_ch.block_address !== want.block_address) begin
                    error_count++;
                    $display("%0t: block_address expected %h got %h",
                             $time, want.block_address, rsp_ch.block_address);
                end
                if (rsp_ch.status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, rsp_ch.status);
                end
            end
        end
    end

    task automatic test_frontier_edges();
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), '0);
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(1));
        write_register(ffga_pkg::CFG_FRONTIER, ADDR_MAX - 1000);
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(1000));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(1));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), '0);
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ADDR_MAX);
        write_register(ffga_pkg::CFG_FRONTIER, '0);
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ADDR_MAX);
        write_register(ffga_pkg::CFG_FRONTIER, ffga_pkg::t_addr'(4096));
    endtask

    task automatic test_gap_edges();
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), '0);
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(4095));
        send_request(ffga_pkg::OP_RELEASE, '0, ffga_pkg::t_addr'(4096));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), '0);
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(4096));
        send_request(ffga_pkg::OP_RELEASE, ADDR_MAX - 99, ADDR_MAX);
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(300));
        send_request(ffga_pkg::OP_RELEASE, ADDR_MAX, ffga_pkg::t_addr'(6000));
        empty_gap_table();
        send_request(ffga_pkg::OP_RELEASE, ffga_pkg::t_addr'(48'h8000_0000_0000),
                     ffga_pkg::t_addr'(6000));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(3000));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(3000));
    endtask

    task automatic test_min_gap_extremes();
        set_min_gap(32'd1);
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(1));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(1));
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(2));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(1));
        empty_gap_table();
        set_min_gap('1);
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(32'hFFFF_FFFE));
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(32'hFFFF_FFFF));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(1));
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(48'h1_0000_0000));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), '0);
        write_register(CFG_SPARE_LO, rand_addr());
        write_register(CFG_SPARE_HI, rand_addr());
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(32'hFFFF_FFFF));
        set_min_gap(ffga_pkg::MIN_GAP_RESET);
        empty_gap_table();
    endtask

    task automatic test_table_full();
        set_min_gap(32'd16);
        steady = 1'b1;
        for (int i = 0; i < ffga_pkg::GAP_SLOTS + 4; i++) begin
            send_request(ffga_pkg::OP_RELEASE, rand_addr(),
                         ffga_pkg::t_addr'($urandom_range(1 << 20, 16)));
        end
        steady = 1'b0;
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), ffga_pkg::t_addr'(8));
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(4096));
        send_request(ffga_pkg::OP_ALLOC, rand_addr(), gap_len[ffga_pkg::GAP_SLOTS/2]);
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(4096));
        send_request(ffga_pkg::OP_RELEASE, rand_addr(), ffga_pkg::t_addr'(4096));
        empty_gap_table();
    endtask

    task automatic test_random_traffic();
        ffga_pkg::t_op op;
        for (int round = 0; round < 4; round++) begin
            case (round)
                0: begin
                    set_min_gap(32'd1);
                    write_register(ffga_pkg::CFG_FRONTIER, '0);
                end
                1: begin
                    set_min_gap(ffga_pkg::MIN_GAP_RESET);
                    write_register(ffga_pkg::CFG_FRONTIER, rand_addr());
                end
                2: begin
                    set_min_gap($urandom_range(1 << 20, 1));
                    write_register(ffga_pkg::CFG_FRONTIER, ADDR_MAX - (rand_addr() >> 8));
                end
                default: begin
                    set_min_gap('1);
                    write_register(ffga_pkg::CFG_FRONTIER, rand_addr() >> 4);
                end
            endcase
            if (round % 2 == 1) begin
                empty_gap_table();
            end
            for (int n = 0; n < 250; n++) begin
                if (n % 64 == 0) begin
                    steady = ($urandom_range(3, 0) == 0);
                end
                if (n % 50 == 0 && occupied_slots() > ffga_pkg::GAP_SLOTS * 3 / 4
                        && $urandom_range(1, 0) == 1) begin
                    empty_gap_table();
                end
                op = ($urandom_range(9, 0) < 4) ? ffga_pkg::OP_RELEASE : ffga_pkg::OP_ALLOC;
                send_request(op, rand_addr(), pick_size());
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = ffga_pkg::OP_ALLOC;
        req_ch.chunk_start = '0;
        req_ch.chunk_size  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = ffga_pkg::CFG_MIN_GAP;
        cfg_ch.data        = '0;
        clear_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_frontier_edges();
        test_gap_edges();
        test_min_gap_extremes();
        test_table_full();
        test_random_traffic();

        settle();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
